// ===== hw/rtl/ldlt_pkg.sv =====
// ldlt_pkg: shared types and codes for the LDL^T solver core.
// Holds the input op codes, the controller state enum and the command struct.
// No dependencies.
package ldlt_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_MAT = 2'd0,
    OP_FACTOR   = 2'd1,
    OP_LOAD_RHS = 2'd2,
    OP_SOLVE    = 2'd3
  } op_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_SOLN   = 1'b1;

  localparam logic CFG_SIZE  = 1'b0;
  localparam logic CFG_FLOOR = 1'b1;

  // vector store selected for the registered vector read
  typedef enum logic [1:0] {
    VS_WORK = 2'd0,
    VS_RHS  = 2'd1,
    VS_INV  = 2'd2
  } vsel_t;

  // accumulator preload source
  typedef enum logic [1:0] {
    INIT_MAT  = 2'd0,
    INIT_ONE  = 2'd1,
    INIT_ZERO = 2'd2,
    INIT_VEC  = 2'd3
  } init_t;

  // multiplier operand pair
  typedef enum logic [1:0] {
    MS_LS = 2'd0,
    MS_LV = 2'd1,
    MS_HI = 2'd2
  } msel_t;

  // write data source
  typedef enum logic [1:0] {
    WS_ACC  = 2'd0,
    WS_PROD = 2'd1,
    WS_ONE  = 2'd2
  } wsrc_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_F_INIT_RD, ST_F_INIT, ST_F_MRD, ST_F_MUL, ST_F_SUB,
    ST_F_PCHK, ST_F_DIV_GO, ST_F_DIV_WAIT, ST_F_SV, ST_F_LMUL, ST_F_LWR, ST_F_DONE,
    ST_S_FW_RD, ST_S_FW_INIT, ST_S_FW_MRD, ST_S_FW_MUL, ST_S_FW_SUB, ST_S_FW_WR,
    ST_S_SC_RD, ST_S_SC_INIT, ST_S_SC_HOLD, ST_S_SC_ILD, ST_S_SC_MUL, ST_S_SC_WR,
    ST_S_BK_RD, ST_S_BK_INIT, ST_S_BK_MRD, ST_S_BK_MUL, ST_S_BK_SUB, ST_S_BK_WR,
    ST_S_OUT_RD, ST_S_OUT
  } state_t;

  typedef struct packed {
    logic  mat_we;
    logic  rhs_we;
    logic  rd_en;
    vsel_t v_sel;
    logic  acc_init;
    init_t init_sel;
    logic  mul_en;
    msel_t mul_sel;
    logic  sub_en;
    logic  wr_s;
    logic  wr_l;
    wsrc_t l_src;
    logic  wr_work;
    wsrc_t work_src;
    logic  hold_ld;
    logic  inv_ld;
    logic  piv_chk;
    logic  div_start;
    logic  wr_inv;
    logic  clr_bad;
    logic  commit;
    logic  out_ld;
    logic  out_kind;
    logic  out_last;
  } dp_cmd_t;

endpackage

// ===== hw/rtl/ldlt_div.sv =====
// ldlt_div: restoring divider, one quotient bit per cycle, for 2^(2F) / d.
// Quotient wraps to 32 bits; a zero divisor gives 0x7FFFFFFF.
// No dependencies.
module ldlt_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [31:0] quo
);
  localparam int QN = 2 * FRAC_BITS + 1;
  localparam int KW = $clog2(QN + 1);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic [30:0]   rem_r, rem_nxt;
  logic [31:0]   quo_r, quo_nxt;
  logic [30:0]   dvs_r, dvs_nxt;
  logic          nbit;
  logic [31:0]   trial;
  logic          fits;

  // numerator has a single one at its top bit
  assign nbit  = (cnt_r == KW'(QN));
  assign trial = {rem_r, nbit};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = KW'(QN);
      rem_nxt = '0;
      quo_nxt = '0;
      dvs_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = fits ? 31'(trial - {1'b0, dvs_r}) : trial[30:0];
      quo_nxt = {quo_r[30:0], fits};
      cnt_nxt = cnt_r - KW'(1);
      if (cnt_r == KW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quo  = (dvs_r == '0) ? 32'h7FFF_FFFF : quo_r;

endmodule

// ===== hw/rtl/ldlt_dp.sv =====
// ldlt_dp: datapath of the solver: entry stores, factor memories, MAC unit,
// pivot check, reciprocal divider and the result register.
// Depends on ldlt_pkg and ldlt_div.
module ldlt_dp
  import ldlt_pkg::*;
#(
  parameter int MAT_SIZE  = 6,
  parameter int FRAC_BITS = 16,
  parameter int IW = $clog2(MAT_SIZE),
  parameter int AW = $clog2(MAT_SIZE * MAT_SIZE)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dp_cmd_t       cmd,
  input  logic [AW-1:0] l_ra,
  input  logic [AW-1:0] s_ra,
  input  logic [AW-1:0] m_ra,
  input  logic [AW-1:0] w_addr,
  input  logic [IW-1:0] v_idx,
  input  logic [31:0]   entry_value,
  input  logic [30:0]   pivot_floor,
  output logic          div_done,
  output logic          out_strobe,
  output logic          out_kind,
  output logic [2:0]    out_index,
  output logic [31:0]   out_value,
  output logic          out_status,
  output logic          out_last
);
  localparam int          DEPTH = MAT_SIZE * MAT_SIZE;
  localparam logic [31:0] ONE_FX = 32'(1) << FRAC_BITS;

  logic [31:0] mat_mem [DEPTH];
  logic [31:0] l_mem   [DEPTH];
  logic [31:0] s_mem   [DEPTH];
  logic [31:0] inv_mem  [MAT_SIZE];
  logic [31:0] rhs_mem  [MAT_SIZE];
  logic [31:0] work_mem [MAT_SIZE];

  logic [31:0] l_q_r, s_q_r, m_q_r, v_q_r;
  logic [63:0] acc_r, prod_r;
  logic [31:0] h_r, inv_r;
  logic        bad_r, sing_r;
  logic        strobe_r;
  logic        kind_r, status_r, last_r;
  logic [2:0]  index_r;
  logic [31:0] value_r;

  logic [31:0] v_mux;
  logic [31:0] acc_nar, prod_nar;
  logic [63:0] init_val;
  logic [31:0] ma, mb;
  logic [63:0] prod_nxt;
  logic [31:0] dj;
  logic        low_piv;
  logic [31:0] l_wd, work_wd;
  logic [31:0] div_quo;

  // helpers on the accumulator format
  function automatic logic [63:0] widen(input logic [31:0] x);
    widen = {{32{x[31]}}, x} << FRAC_BITS;
  endfunction

  assign acc_nar  = acc_r[FRAC_BITS +: 32];
  assign prod_nar = prod_r[FRAC_BITS +: 32];

  // vector store read select
  always_comb begin
    case (cmd.v_sel)
      VS_RHS:  v_mux = rhs_mem[v_idx];
      VS_INV:  v_mux = inv_mem[v_idx];
      default: v_mux = work_mem[v_idx];
    endcase
  end

  // accumulator preload
  always_comb begin
    case (cmd.init_sel)
      INIT_MAT:  init_val = widen(m_q_r);
      INIT_ONE:  init_val = widen(ONE_FX);
      INIT_VEC:  init_val = widen(v_q_r);
      default:   init_val = '0;
    endcase
  end

  // multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MS_LV:   begin ma = l_q_r; mb = v_q_r; end
      MS_HI:   begin ma = h_r;   mb = inv_r; end
      default: begin ma = l_q_r; mb = s_q_r; end
    endcase
  end
  assign prod_nxt = 64'($signed({{32{ma[31]}}, ma}) * $signed({{32{mb[31]}}, mb}));

  // pivot check against the floor; a low pivot becomes one
  assign low_piv = ($signed(acc_nar) < $signed({1'b0, pivot_floor}));
  assign dj      = low_piv ? ONE_FX : acc_nar;

  // write data selects
  always_comb begin
    case (cmd.l_src)
      WS_PROD: l_wd = prod_nar;
      WS_ONE:  l_wd = ONE_FX;
      default: l_wd = acc_nar;
    endcase
    case (cmd.work_src)
      WS_PROD: work_wd = prod_nar;
      WS_ONE:  work_wd = ONE_FX;
      default: work_wd = acc_nar;
    endcase
  end

  // matrix memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.mat_we)
      mat_mem[w_addr] <= entry_value;
    if (cmd.wr_l)
      l_mem[w_addr] <= l_wd;
    if (cmd.wr_s)
      s_mem[w_addr] <= acc_nar;
    if (cmd.rd_en) begin
      m_q_r <= mat_mem[m_ra];
      l_q_r <= l_mem[l_ra];
      s_q_r <= s_mem[s_ra];
    end
  end

  // vector stores
  always_ff @(posedge clk) begin
    if (cmd.rhs_we)
      rhs_mem[v_idx] <= entry_value;
    if (cmd.wr_work)
      work_mem[v_idx] <= work_wd;
    if (cmd.wr_inv)
      inv_mem[v_idx] <= div_quo;
    if (cmd.rd_en)
      v_q_r <= v_mux;
  end

  // accumulator, product and holding registers
  always_ff @(posedge clk) begin
    if (cmd.acc_init)
      acc_r <= init_val;
    else if (cmd.sub_en)
      acc_r <= acc_r - prod_r;
    if (cmd.mul_en)
      prod_r <= prod_nxt;
    if (cmd.piv_chk)
      h_r <= dj;
    else if (cmd.hold_ld)
      h_r <= acc_nar;
    if (cmd.wr_inv)
      inv_r <= div_quo;
    else if (cmd.inv_ld)
      inv_r <= v_q_r;
  end

  // status flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_r  <= 1'b0;
      sing_r <= 1'b0;
    end else begin
      if (cmd.clr_bad)
        bad_r <= 1'b0;
      else if (cmd.piv_chk && low_piv)
        bad_r <= 1'b1;
      if (cmd.commit)
        sing_r <= bad_r;
    end
  end

  ldlt_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .divisor(h_r[30:0]),
    .done   (div_done),
    .quo    (div_quo)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n)
      strobe_r <= 1'b0;
    else
      strobe_r <= cmd.out_ld;
    if (cmd.out_ld) begin
      kind_r   <= cmd.out_kind;
      last_r   <= cmd.out_last;
      index_r  <= (cmd.out_kind == KIND_SOLN) ? 3'(v_idx) : 3'd0;
      value_r  <= (cmd.out_kind == KIND_SOLN) ? v_q_r : 32'd0;
      status_r <= (cmd.out_kind == KIND_SOLN) ? sing_r : bad_r;
    end
  end

  assign out_strobe = strobe_r;
  assign out_kind   = kind_r;
  assign out_index  = index_r;
  assign out_value  = value_r;
  assign out_status = status_r;
  assign out_last   = last_r;

endmodule

// ===== hw/rtl/ldlt_ctrl.sv =====
// ldlt_ctrl: sequencer for load, factor and solve items; owns loop counters
// and drives datapath commands and addresses.
// Depends on ldlt_pkg.
module ldlt_ctrl
  import ldlt_pkg::*;
#(
  parameter int MAT_SIZE = 6,
  parameter int IW = $clog2(MAT_SIZE),
  parameter int AW = $clog2(MAT_SIZE * MAT_SIZE),
  parameter int CW = $clog2(MAT_SIZE + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    op,
  input  logic [2:0]    row,
  input  logic [2:0]    col,
  input  logic [2:0]    size_in_use,
  input  logic          div_done,
  output logic          busy,
  output dp_cmd_t       cmd,
  output logic [AW-1:0] l_ra,
  output logic [AW-1:0] s_ra,
  output logic [AW-1:0] m_ra,
  output logic [AW-1:0] w_addr,
  output logic [IW-1:0] v_idx
);
  localparam logic [AW-1:0] NA = AW'(MAT_SIZE);
  localparam logic [CW-1:0] NL = CW'(MAT_SIZE);

  state_t        state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, p_r, p_nxt, r_r, r_nxt;
  logic [CW-1:0] n_act;
  logic          go;
  op_t           op_in;
  logic          row_ok, col_ok;

  function automatic logic [AW-1:0] addr(input logic [CW-1:0] a, input logic [CW-1:0] b);
    addr = AW'(a[IW-1:0]) * NA + AW'(b[IW-1:0]);
  endfunction

  assign go     = start && (state_r == ST_IDLE);
  assign op_in  = op_t'(op);
  assign row_ok = (32'(row) < MAT_SIZE);
  assign col_ok = (32'(col) < MAT_SIZE);
  assign busy   = (state_r != ST_IDLE);

  // order of the system, clamped to 1..MAT_SIZE
  always_comb begin
    if (size_in_use == 3'd0)
      n_act = CW'(1);
    else if (32'(size_in_use) > MAT_SIZE)
      n_act = NL;
    else
      n_act = CW'(size_in_use);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go && op_in == OP_FACTOR)
          state_nxt = ST_F_INIT_RD;
        else if (go && op_in == OP_SOLVE)
          state_nxt = ST_S_FW_RD;
      end
      ST_F_INIT_RD: state_nxt = ST_F_INIT;
      ST_F_INIT, ST_F_SUB: begin
        if (p_nxt < j_r)
          state_nxt = ST_F_MRD;
        else if (r_r == j_r)
          state_nxt = ST_F_PCHK;
        else
          state_nxt = ST_F_SV;
      end
      ST_F_MRD:     state_nxt = ST_F_MUL;
      ST_F_MUL:     state_nxt = ST_F_SUB;
      ST_F_PCHK:    state_nxt = ST_F_DIV_GO;
      ST_F_DIV_GO:  state_nxt = ST_F_DIV_WAIT;
      ST_F_DIV_WAIT: begin
        if (div_done)
          state_nxt = (j_r + CW'(1) < NL) ? ST_F_INIT_RD : ST_F_DONE;
      end
      ST_F_SV:      state_nxt = ST_F_LMUL;
      ST_F_LMUL:    state_nxt = ST_F_LWR;
      ST_F_LWR:     state_nxt = ST_F_INIT_RD;
      ST_F_DONE:    state_nxt = ST_IDLE;
      ST_S_FW_RD:   state_nxt = ST_S_FW_INIT;
      ST_S_FW_INIT, ST_S_FW_SUB:
        state_nxt = (p_nxt < i_r) ? ST_S_FW_MRD : ST_S_FW_WR;
      ST_S_FW_MRD:  state_nxt = ST_S_FW_MUL;
      ST_S_FW_MUL:  state_nxt = ST_S_FW_SUB;
      ST_S_FW_WR:   state_nxt = (i_r + CW'(1) < NL) ? ST_S_FW_RD : ST_S_SC_RD;
      ST_S_SC_RD:   state_nxt = ST_S_SC_INIT;
      ST_S_SC_INIT: state_nxt = ST_S_SC_HOLD;
      ST_S_SC_HOLD: state_nxt = ST_S_SC_ILD;
      ST_S_SC_ILD:  state_nxt = ST_S_SC_MUL;
      ST_S_SC_MUL:  state_nxt = ST_S_SC_WR;
      ST_S_SC_WR:   state_nxt = (i_r + CW'(1) < NL) ? ST_S_SC_RD : ST_S_BK_RD;
      ST_S_BK_RD:   state_nxt = ST_S_BK_INIT;
      ST_S_BK_INIT, ST_S_BK_SUB:
        state_nxt = (p_nxt < NL) ? ST_S_BK_MRD : ST_S_BK_WR;
      ST_S_BK_MRD:  state_nxt = ST_S_BK_MUL;
      ST_S_BK_MUL:  state_nxt = ST_S_BK_SUB;
      ST_S_BK_WR:   state_nxt = (i_r == '0) ? ST_S_OUT_RD : ST_S_BK_RD;
      ST_S_OUT_RD:  state_nxt = ST_S_OUT;
      ST_S_OUT:     state_nxt = (i_r + CW'(1) < n_act) ? ST_S_OUT_RD : ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // loop counters
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    p_nxt = p_r;
    r_nxt = r_r;
    case (state_r)
      ST_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
        r_nxt = '0;
      end
      ST_F_INIT, ST_S_FW_INIT: p_nxt = '0;
      ST_F_SUB, ST_S_FW_SUB, ST_S_BK_SUB: p_nxt = p_r + CW'(1);
      ST_F_DIV_WAIT: if (div_done) r_nxt = j_r + CW'(1);
      ST_F_LWR: begin
        if (r_r + CW'(1) < NL) begin
          r_nxt = r_r + CW'(1);
        end else begin
          j_nxt = j_r + CW'(1);
          r_nxt = j_r + CW'(1);
        end
      end
      ST_S_FW_WR: i_nxt = (i_r + CW'(1) < NL) ? i_r + CW'(1) : '0;
      ST_S_SC_WR: i_nxt = (i_r + CW'(1) < NL) ? i_r + CW'(1) : NL - CW'(1);
      ST_S_BK_INIT: p_nxt = i_r + CW'(1);
      ST_S_BK_WR: if (i_r != '0) i_nxt = i_r - CW'(1);
      ST_S_OUT: i_nxt = i_r + CW'(1);
      default: ;
    endcase
  end

  // datapath commands and addresses
  always_comb begin
    cmd          = '0;
    cmd.v_sel    = VS_WORK;
    cmd.init_sel = INIT_ZERO;
    cmd.mul_sel  = MS_LS;
    cmd.l_src    = WS_ACC;
    cmd.work_src = WS_ACC;
    l_ra   = addr(r_r, p_r);
    s_ra   = addr(j_r, p_r);
    m_ra   = addr(r_r, j_r);
    w_addr = addr(r_r, j_r);
    v_idx  = i_r[IW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        w_addr = AW'(row) * NA + AW'(col);
        v_idx  = IW'(row);
        cmd.mat_we  = go && op_in == OP_LOAD_MAT && row_ok && col_ok;
        cmd.rhs_we  = go && op_in == OP_LOAD_RHS && row_ok;
        cmd.clr_bad = go && op_in == OP_FACTOR;
      end
      ST_F_INIT_RD, ST_F_MRD: cmd.rd_en = 1'b1;
      ST_F_INIT: begin
        cmd.acc_init = 1'b1;
        if (r_r < n_act && j_r < n_act)
          cmd.init_sel = INIT_MAT;
        else if (r_r == j_r)
          cmd.init_sel = INIT_ONE;
        else
          cmd.init_sel = INIT_ZERO;
      end
      ST_F_MUL: cmd.mul_en = 1'b1;
      ST_F_SUB: cmd.sub_en = 1'b1;
      ST_F_PCHK: cmd.piv_chk = 1'b1;
      ST_F_DIV_GO: cmd.div_start = 1'b1;
      ST_F_DIV_WAIT: begin
        v_idx      = j_r[IW-1:0];
        cmd.wr_inv = div_done;
        cmd.wr_l   = div_done;
        cmd.l_src  = WS_ONE;
      end
      ST_F_SV: begin
        cmd.wr_s    = 1'b1;
        cmd.hold_ld = 1'b1;
      end
      ST_F_LMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_HI;
      end
      ST_F_LWR: begin
        cmd.wr_l  = 1'b1;
        cmd.l_src = WS_PROD;
      end
      ST_F_DONE: begin
        cmd.commit   = 1'b1;
        cmd.out_ld   = 1'b1;
        cmd.out_kind = KIND_STATUS;
        cmd.out_last = 1'b1;
      end
      ST_S_FW_RD: begin
        cmd.rd_en = 1'b1;
        cmd.v_sel = VS_RHS;
      end
      ST_S_FW_INIT: begin
        cmd.acc_init = 1'b1;
        cmd.init_sel = (i_r < n_act) ? INIT_VEC : INIT_ZERO;
      end
      ST_S_FW_MRD: begin
        cmd.rd_en = 1'b1;
        l_ra      = addr(i_r, p_r);
        v_idx     = p_r[IW-1:0];
      end
      ST_S_FW_MUL, ST_S_BK_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_LV;
      end
      ST_S_FW_SUB, ST_S_BK_SUB: cmd.sub_en = 1'b1;
      ST_S_FW_WR, ST_S_BK_WR: cmd.wr_work = 1'b1;
      ST_S_SC_RD, ST_S_BK_RD, ST_S_OUT_RD: cmd.rd_en = 1'b1;
      ST_S_SC_INIT, ST_S_BK_INIT: begin
        cmd.acc_init = 1'b1;
        cmd.init_sel = INIT_VEC;
      end
      ST_S_SC_HOLD: begin
        cmd.hold_ld = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.v_sel   = VS_INV;
      end
      ST_S_SC_ILD: cmd.inv_ld = 1'b1;
      ST_S_SC_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_HI;
      end
      ST_S_SC_WR: begin
        cmd.wr_work  = 1'b1;
        cmd.work_src = WS_PROD;
      end
      ST_S_BK_MRD: begin
        cmd.rd_en = 1'b1;
        l_ra      = addr(p_r, i_r);
        v_idx     = p_r[IW-1:0];
      end
      ST_S_OUT: begin
        cmd.out_ld   = 1'b1;
        cmd.out_kind = KIND_SOLN;
        cmd.out_last = (i_r + CW'(1) == n_act);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      p_r     <= '0;
      r_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      p_r     <= p_nxt;
      r_r     <= r_nxt;
    end
  end

endmodule

// ===== hw/rtl/ldlt_linear_solver_core.sv =====
// ldlt_linear_solver_core: top level of the fixed-point LDL^T solver.
// Holds the configuration registers; instantiates ldlt_ctrl and ldlt_dp.
// Depends on ldlt_pkg, ldlt_ctrl and ldlt_dp.
//
// Usage:
//  - Items are issued with start while busy is low, carrying in_op, in_row,
//    in_col and in_entry_value. Loads of matrix or rhs entries are written
//    straight from idle and never raise busy; out-of-range indices are dropped.
//  - A factor item runs the whole LDL^T sweep, then emits one status beat.
//    Each multiply-accumulate is a registered memory read, a multiply and a
//    subtract; each pivot reciprocal runs the bit-serial divider plus its
//    start and handoff states.
//  - A solve item runs forward substitution, scaling and back substitution
//    over all MAT_SIZE rows, then emits one solution beat per row of the
//    order size_in_use (clamped to 1..MAT_SIZE), each after a registered read.
//  - Results appear for one cycle with out_strobe; the receiver takes every
//    beat and cannot stall the block.
//  - Config writes (cfg_valid, always ready) are meant for idle periods.
//  - Reset returns the sequencer to idle, clears the singular flag and sets
//    size_in_use to 6 and pivot_floor to 1; stored entries are undefined.
module ldlt_linear_solver_core
  import ldlt_pkg::*;
#(
  parameter int MAT_SIZE  = 6,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [2:0]  in_row,
  input  logic [2:0]  in_col,
  input  logic [31:0] in_entry_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_strobe,
  output logic        out_kind,
  output logic [2:0]  out_index,
  output logic [31:0] out_value,
  output logic        out_status,
  output logic        out_last
);
  localparam int IW = $clog2(MAT_SIZE);
  localparam int AW = $clog2(MAT_SIZE * MAT_SIZE);
  localparam int CW = $clog2(MAT_SIZE + 1);

  logic [2:0]    size_r;
  logic [30:0]   floor_r;
  dp_cmd_t       cmd;
  logic [AW-1:0] l_ra, s_ra, m_ra, w_addr;
  logic [IW-1:0] v_idx;
  logic          div_done;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= 3'd6;
      floor_r <= 31'd1;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SIZE)
        size_r <= cfg_data[2:0];
      else
        floor_r <= cfg_data[30:0];
    end
  end

  ldlt_ctrl #(
    .MAT_SIZE(MAT_SIZE),
    .IW      (IW),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .op         (in_op),
    .row        (in_row),
    .col        (in_col),
    .size_in_use(size_r),
    .div_done   (div_done),
    .busy       (busy),
    .cmd        (cmd),
    .l_ra       (l_ra),
    .s_ra       (s_ra),
    .m_ra       (m_ra),
    .w_addr     (w_addr),
    .v_idx      (v_idx)
  );

  ldlt_dp #(
    .MAT_SIZE (MAT_SIZE),
    .FRAC_BITS(FRAC_BITS),
    .IW       (IW),
    .AW       (AW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .l_ra       (l_ra),
    .s_ra       (s_ra),
    .m_ra       (m_ra),
    .w_addr     (w_addr),
    .v_idx      (v_idx),
    .entry_value(in_entry_value),
    .pivot_floor(floor_r),
    .div_done   (div_done),
    .out_strobe (out_strobe),
    .out_kind   (out_kind),
    .out_index  (out_index),
    .out_value  (out_value),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule
